### rtl/core/psc_pkg.sv
// Shared types, constants and helper functions of the pressure sensor compensation block.
// No dependencies; every other file of the block but psc_queue imports this package.
package psc_pkg;

  // Width of the compensation datapath and number of quotient bits.
  localparam int DataW = 32;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_TEMP_COEFFS  = 2'd0,
    REG_PRESS_LOW    = 2'd1,
    REG_PRESS_HIGH   = 2'd2,
    REG_PRESS_NINE   = 2'd3
  } psc_reg_t;

  // Constants of the compensation formulas.
  localparam logic [31:0] PressOffset = 32'd64000;
  localparam logic [31:0] DivBias     = 32'd32768;
  localparam logic [31:0] RawFull     = 32'd1048576;
  localparam logic [31:0] PressScale  = 32'd3125;
  localparam logic [31:0] SignBit     = 32'h8000_0000;
  localparam logic [31:0] TempRound   = 32'd128;

  // Calibration coefficients, as stored in the configuration registers.
  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } psc_coef_t;

  // Item handed from the front to the back: temperature, scaled numerator, divisor.
  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] numer;
    logic [31:0] divisor;
  } psc_mid_t;

  // Finished result.
  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] press;
    logic        fault;
  } psc_res_t;

  // Arithmetic right shift of a 32-bit two's complement value.
  function automatic logic [31:0] sra32(input logic [31:0] x, input int unsigned n);
    logic signed [31:0] s;
    s = $signed(x);
    return $unsigned(s >>> n);
  endfunction

  // Sign extension of a 16-bit coefficient.
  function automatic logic [31:0] sext16(input logic [15:0] x);
    return {{16{x[15]}}, x};
  endfunction

endpackage

### rtl/core/psc_queue.sv
// Small first-in first-out queue with a fill count.
// Depends on nothing; used between front and back and at the result side.
module psc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             wr, rd;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign wr    = push && !full;
  assign rd    = pop && !empty;
  assign rdata = mem[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (wr) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({wr, rd})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage write.
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue fill count beyond depth");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (wr && !rd) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not rise on a lone write");
  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (empty || full) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with fill count");
`endif

endmodule

### rtl/core/psc_front.sv
// Front pipeline: temperature compensation and pressure divisor and numerator.
// Depends on psc_pkg; feeds the queue in front of psc_back.
module psc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [19:0]         in_raw_pressure,
  input  logic [19:0]         in_raw_temperature,
  input  psc_pkg::psc_coef_t  coef,
  output logic                out_valid,
  output psc_pkg::psc_mid_t   out_item
);
  import psc_pkg::*;

  localparam int Stages = 9;

  logic [Stages-1:0] v_r;

  logic [19:0] adcp0_r, adct0_r;
  logic [19:0] adcp1_r, adcp2_r, adcp3_r, adcp4_r, adcp5_r, adcp6_r, adcp7_r;
  logic [31:0] m1_r, m2_r;
  logic [31:0] a2_r, m3_r;
  logic [31:0] temp3_r, temp4_r, temp5_r, temp6_r, temp7_r, temp8_r;
  logic [31:0] pa3_r, dp3_r;
  logic [31:0] dd4_r, ap5_4_r, p2a4_r;
  logic [31:0] b6_5_r, p3x5_r, ap5_5_r, p2a5_r;
  logic [31:0] b6_r, s6_r;
  logic [31:0] m7_r, b7_r;
  logic [31:0] a8_r, pm8_r;

  logic [31:0] fine3, t5, bsum6, x6, num8;

  // Valid bits move with the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[Stages-2:0], in_valid};
    end
  end

  // Combinational pieces between registers.
  always_comb begin
    fine3 = a2_r + sra32(m3_r, 14);
    t5    = (fine3 << 2) + fine3;
    bsum6 = sra32(b6_5_r + (ap5_5_r << 1), 2) + {coef.p4, 16'h0000};
    x6    = sra32(sra32(p3x5_r, 3) + sra32(p2a5_r, 1), 18);
    num8  = (RawFull - {12'h000, adcp7_r}) - sra32(b7_r, 12);
  end

  // Datapath registers; each multiplication ends at a register.
  always_ff @(posedge clk) begin
    if (en) begin
      adcp0_r <= in_raw_pressure;
      adct0_r <= in_raw_temperature;
      // Temperature products.
      m1_r    <= (({12'h000, adct0_r} >> 3) - ({16'h0000, coef.t1} << 1)) * sext16(coef.t2);
      m2_r    <= (({12'h000, adct0_r} >> 4) - {16'h0000, coef.t1})
               * (({12'h000, adct0_r} >> 4) - {16'h0000, coef.t1});
      adcp1_r <= adcp0_r;
      a2_r    <= sra32(m1_r, 11);
      m3_r    <= sra32(m2_r, 12) * sext16(coef.t3);
      adcp2_r <= adcp1_r;
      // Fine value, temperature and pressure offsets.
      temp3_r <= sra32(t5 + TempRound, 8);
      pa3_r   <= sra32(fine3, 1) - PressOffset;
      dp3_r   <= sra32(sra32(fine3, 1) - PressOffset, 2);
      adcp3_r <= adcp2_r;
      // First pressure products.
      dd4_r   <= dp3_r * dp3_r;
      ap5_4_r <= pa3_r * sext16(coef.p5);
      p2a4_r  <= sext16(coef.p2) * pa3_r;
      temp4_r <= temp3_r;
      adcp4_r <= adcp3_r;
      // Second pressure products.
      b6_5_r  <= sra32(dd4_r, 11) * sext16(coef.p6);
      p3x5_r  <= sext16(coef.p3) * sra32(dd4_r, 13);
      ap5_5_r <= ap5_4_r;
      p2a5_r  <= p2a4_r;
      temp5_r <= temp4_r;
      adcp5_r <= adcp4_r;
      // Sums ahead of the divisor product.
      b6_r    <= bsum6;
      s6_r    <= DivBias + x6;
      temp6_r <= temp5_r;
      adcp6_r <= adcp5_r;
      m7_r    <= s6_r * {16'h0000, coef.p1};
      b7_r    <= b6_r;
      temp7_r <= temp6_r;
      adcp7_r <= adcp6_r;
      // Divisor and scaled numerator.
      a8_r    <= sra32(m7_r, 15);
      pm8_r   <= num8 * PressScale;
      temp8_r <= temp7_r;
    end
  end

  assign out_valid        = v_r[Stages-1];
  assign out_item.temp    = temp8_r;
  assign out_item.numer   = pm8_r;
  assign out_item.divisor = a8_r;

endmodule

### rtl/core/psc_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband data.
// Depends on psc_pkg; instantiated by psc_back.
module psc_divider #(
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [31:0]       dividend,
  input  logic [31:0]       divisor,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [31:0]       quotient,
  output logic [SIDE_W-1:0] out_side
);
  import psc_pkg::*;

  logic [DataW-1:0]  v_r;
  logic [31:0]       rem_r  [DataW];
  logic [31:0]       quo_r  [DataW];
  logic [31:0]       dvs_r  [DataW];
  logic [SIDE_W-1:0] side_r [DataW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[DataW-2:0], in_valid};
    end
  end

  // One shift and conditional subtract per stage.
  for (genvar k = 0; k < DataW; k++) begin : g_step
    logic [31:0]       src_rem, src_quo, src_dvs;
    logic [SIDE_W-1:0] src_side;
    logic [32:0]       trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign src_rem  = '0;
      assign src_quo  = dividend;
      assign src_dvs  = divisor;
      assign src_side = in_side;
    end else begin : g_next
      assign src_rem  = rem_r[k-1];
      assign src_quo  = quo_r[k-1];
      assign src_dvs  = dvs_r[k-1];
      assign src_side = side_r[k-1];
    end

    assign trial = {src_rem, src_quo[31]};
    assign ge    = (trial >= {1'b0, src_dvs});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? 32'(trial - {1'b0, src_dvs}) : trial[31:0];
        quo_r[k]  <= {src_quo[30:0], ge};
        dvs_r[k]  <= src_dvs;
        side_r[k] <= src_side;
      end
    end
  end

  assign out_valid = v_r[DataW-1];
  assign quotient  = quo_r[DataW-1];
  assign out_side  = side_r[DataW-1];

endmodule

### rtl/core/psc_back.sv
// Back pipeline: divide setup, pipelined division and the final pressure correction.
// Depends on psc_pkg and psc_divider; fed from the queue behind psc_front.
module psc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  psc_pkg::psc_mid_t  in_item,
  input  psc_pkg::psc_coef_t coef,
  output logic               out_valid,
  output psc_pkg::psc_res_t  out_item
);
  import psc_pkg::*;

  localparam int SideW = 34;

  logic        v0_r, v1_r, v2_r, v3_r;
  logic [31:0] dvd0_r, dvs0_r, temp0_r;
  logic        mode0_r, fault0_r;

  logic              dv_valid;
  logic [31:0]       dv_quo;
  logic [SideW-1:0]  dv_side;
  logic [31:0]       q;

  logic [31:0] p1_r, dd1_r, b8m1_r, temp1_r;
  logic        fault1_r;
  logic [31:0] p2_r, m9_r, bb2_r, temp2_r;
  logic        fault2_r;
  logic [31:0] press3_r, temp3_r;
  logic        fault3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= dv_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Divide setup: a numerator with the sign bit set is divided first and doubled after.
  always_ff @(posedge clk) begin
    if (en) begin
      mode0_r  <= (in_item.numer >= SignBit);
      dvd0_r   <= (in_item.numer < SignBit) ? (in_item.numer << 1) : in_item.numer;
      dvs0_r   <= in_item.divisor;
      fault0_r <= (in_item.divisor == '0);
      temp0_r  <= in_item.temp;
    end
  end

  psc_divider #(
    .SIDE_W (SideW)
  ) u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v0_r),
    .dividend  (dvd0_r),
    .divisor   (dvs0_r),
    .in_side   ({temp0_r, fault0_r, mode0_r}),
    .out_valid (dv_valid),
    .quotient  (dv_quo),
    .out_side  (dv_side)
  );

  assign q = dv_side[0] ? (dv_quo << 1) : dv_quo;

  // Final correction over three stages.
  always_ff @(posedge clk) begin
    if (en) begin
      p1_r     <= q;
      dd1_r    <= (q >> 3) * (q >> 3);
      b8m1_r   <= (q >> 2) * sext16(coef.p8);
      temp1_r  <= dv_side[33:2];
      fault1_r <= dv_side[1];
      p2_r     <= p1_r;
      m9_r     <= sext16(coef.p9) * (dd1_r >> 13);
      bb2_r    <= sra32(b8m1_r, 13);
      temp2_r  <= temp1_r;
      fault2_r <= fault1_r;
      press3_r <= fault2_r ? '0
                : p2_r + sra32(sra32(m9_r, 12) + bb2_r + sext16(coef.p7), 4);
      temp3_r  <= temp2_r;
      fault3_r <= fault2_r;
    end
  end

  assign out_valid      = v3_r;
  assign out_item.temp  = temp3_r;
  assign out_item.press = press3_r;
  assign out_item.fault = fault3_r;

endmodule

### rtl/core/pressure_sensor_compensation.sv
// Top level of the pressure sensor compensation block: configuration registers,
// front and back pipelines and the two queues. Depends on psc_pkg and all psc_ modules.
//
// Usage:
//   Input channel: drive in_raw_pressure and in_raw_temperature with in_push; a transfer
//   happens on a rising edge with in_push high and in_full low. One item may be taken
//   every cycle.
//   Result channel: while out_empty is low the oldest result sits on the out_ ports; a
//   transfer happens on a rising edge with out_pop high and out_empty low.
//   Configuration: cfg_we writes cfg_data into register cfg_index; write only
//   while no items are in flight. Coefficient fields follow the register layout.
//   Path: from input transfer to the result showing, an item passes the
//   nine-stage front pipeline, the middle queue, the divide setup stage, the 32-stage
//   divider and the three correction stages. Throughput: one item per cycle while nothing stalls.
//   Stalls: when the result queue fills the back pipeline holds, the middle queue then
//   fills, the front pipeline holds and in_full rises. Nothing is dropped.
//   Reset: synchronous, active low; clears the coefficients, queues and valid bits.
module pressure_sensor_compensation #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [19:0] in_raw_pressure,
  input  logic [19:0] in_raw_temperature,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_temperature_centi,
  output logic [31:0] out_pressure_pa,
  output logic        out_divide_fault,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import psc_pkg::*;

  logic [47:0] temp_coeffs_r;
  logic [63:0] press_low_r, press_high_r;
  logic [15:0] press_nine_r;
  psc_coef_t   coef;

  logic      front_en, front_valid, mid_full, mid_empty;
  psc_mid_t  front_item, mid_item;
  logic      back_en, back_valid, res_full;
  psc_res_t  back_item, res_item;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_coeffs_r <= '0;
      press_low_r   <= '0;
      press_high_r  <= '0;
      press_nine_r  <= '0;
    end else if (cfg_we) begin
      unique case (psc_reg_t'(cfg_index))
        REG_TEMP_COEFFS: temp_coeffs_r <= cfg_data[47:0];
        REG_PRESS_LOW:   press_low_r   <= cfg_data;
        REG_PRESS_HIGH:  press_high_r  <= cfg_data;
        REG_PRESS_NINE:  press_nine_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Coefficient unpacking.
  assign coef.t1 = temp_coeffs_r[15:0];
  assign coef.t2 = temp_coeffs_r[31:16];
  assign coef.t3 = temp_coeffs_r[47:32];
  assign coef.p1 = press_low_r[15:0];
  assign coef.p2 = press_low_r[31:16];
  assign coef.p3 = press_low_r[47:32];
  assign coef.p4 = press_low_r[63:48];
  assign coef.p5 = press_high_r[15:0];
  assign coef.p6 = press_high_r[31:16];
  assign coef.p7 = press_high_r[47:32];
  assign coef.p8 = press_high_r[63:48];
  assign coef.p9 = press_nine_r;

  // Each pipeline holds only when its finished item cannot leave.
  assign front_en = !(front_valid && mid_full);
  assign back_en  = !(back_valid && res_full);
  assign in_full  = !front_en;

  psc_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .en                 (front_en),
    .in_valid           (in_push),
    .in_raw_pressure    (in_raw_pressure),
    .in_raw_temperature (in_raw_temperature),
    .coef               (coef),
    .out_valid          (front_valid),
    .out_item           (front_item)
  );

  psc_queue #(
    .WIDTH ($bits(psc_mid_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (front_valid && front_en),
    .wdata (front_item),
    .full  (mid_full),
    .pop   (back_en),
    .rdata (mid_item),
    .empty (mid_empty)
  );

  psc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (back_en),
    .in_valid  (!mid_empty),
    .in_item   (mid_item),
    .coef      (coef),
    .out_valid (back_valid),
    .out_item  (back_item)
  );

  psc_queue #(
    .WIDTH ($bits(psc_res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (back_valid && back_en),
    .wdata (back_item),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_item),
    .empty (out_empty)
  );

  assign out_temperature_centi = res_item.temp;
  assign out_pressure_pa       = res_item.press;
  assign out_divide_fault      = res_item.fault;

endmodule

### verif/tb_pressure_sensor_compensation.sv
// Testbench for the pressure sensor compensation block. It checks every result against
// a predictor of the 32-bit integer compensation. Depends on psc_pkg and the block's RTL.
`timescale 1ns / 1ps

// Calibration values, the expected results and their in-order checking.
class comp_scoreboard;
  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] press;
    logic        fault;
  } comp_res_t;

  logic [47:0] temp_reg;
  logic [63:0] press_lo_reg;
  logic [63:0] press_hi_reg;
  logic [15:0] press_nine_reg;
  comp_res_t   pending_results[$];
  int          errors;

  function new();
    temp_reg = '0;
    press_lo_reg = '0;
    press_hi_reg = '0;
    press_nine_reg = '0;
    errors = 0;
  endfunction

  // Keep the local copy of a register in step with a write to the block.
  function void note_config(psc_pkg::psc_reg_t idx, logic [63:0] data);
    case (idx)
      psc_pkg::REG_TEMP_COEFFS: temp_reg = data[47:0];
      psc_pkg::REG_PRESS_LOW:   press_lo_reg = data;
      psc_pkg::REG_PRESS_HIGH:  press_hi_reg = data;
      psc_pkg::REG_PRESS_NINE:  press_nine_reg = data[15:0];
      default: ;
    endcase
  endfunction

  function logic [31:0] asr(logic [31:0] x, int n);
    logic signed [31:0] s;
    s = x;
    return s >>> n;
  endfunction

  function logic [31:0] sx(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // Compensation of one sample pair with the current calibration.
  function comp_res_t compensate(logic [19:0] raw_p, logic [19:0] raw_t);
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] adc_p, adc_t, a, b, d, fine, temp, p, dd;
    comp_res_t r;
    adc_p = {12'd0, raw_p};
    adc_t = {12'd0, raw_t};
    t1 = {16'd0, temp_reg[15:0]};
    t2 = sx(temp_reg[31:16]);
    t3 = sx(temp_reg[47:32]);
    p1 = {16'd0, press_lo_reg[15:0]};
    p2 = sx(press_lo_reg[31:16]);
    p3 = sx(press_lo_reg[47:32]);
    p4 = sx(press_lo_reg[63:48]);
    p5 = sx(press_hi_reg[15:0]);
    p6 = sx(press_hi_reg[31:16]);
    p7 = sx(press_hi_reg[47:32]);
    p8 = sx(press_hi_reg[63:48]);
    p9 = sx(press_nine_reg);
    r.fault = 1'b0;

    // Temperature path; the fine value feeds the pressure path.
    a = (adc_t >> 3) - (t1 << 1);
    a = asr(a * t2, 11);
    d = (adc_t >> 4) - t1;
    dd = d * d;
    b = asr(dd, 12) * t3;
    b = asr(b, 14);
    fine = a + b;
    temp = fine * 32'd5 + 32'd128;
    temp = asr(temp, 8);

    // Pressure path up to the divisor.
    a = asr(fine, 1) - 32'd64000;
    d = asr(a, 2);
    dd = d * d;
    b = asr(dd, 11) * p6;
    b = b + ((a * p5) << 1);
    b = asr(b, 2) + (p4 << 16);
    a = asr(p3 * asr(dd, 13), 3) + asr(p2 * a, 1);
    a = asr(a, 18);
    a = (32'd32768 + a) * p1;
    a = asr(a, 15);

    if (a == 32'd0) begin
      p = '0;
      r.fault = 1'b1;
    end else begin
      p = ((32'd1048576 - adc_p) - asr(b, 12)) * 32'd3125;
      if (p < 32'h8000_0000) p = (p << 1) / a;
      else p = (p / a) * 32'd2;
      d = p >> 3;
      dd = d * d;
      a = asr(p9 * (dd >> 13), 12);
      b = asr((p >> 2) * p8, 13);
      p = p + asr(a + b + p7, 4);
    end
    r.temp = temp;
    r.press = p;
    return r;
  endfunction

  function void note_input(logic [19:0] raw_p, logic [19:0] raw_t);
    pending_results.push_back(compensate(raw_p, raw_t));
  endfunction

  function void check_result(logic [31:0] temp, logic [31:0] press, logic fault);
    comp_res_t e;
    if (pending_results.size() == 0) begin
      $error("result with no expectation: temp %0d press %0d fault %0d",
             $signed(temp), press, fault);
      errors++;
      return;
    end
    e = pending_results.pop_front();
    if (temp !== e.temp) begin
      $error("temperature_centi: expected %0d, got %0d", $signed(e.temp), $signed(temp));
      errors++;
    end
    if (press !== e.press) begin
      $error("pressure_pa: expected %0d, got %0d", e.press, press);
      errors++;
    end
    if (fault !== e.fault) begin
      $error("divide_fault: expected %0d, got %0d", e.fault, fault);
      errors++;
    end
  endfunction
endclass

module tb_pressure_sensor_compensation;
  import psc_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [19:0] in_raw_pressure;
  logic [19:0] in_raw_temperature;
  logic        out_empty;
  logic        out_pop;
  logic [31:0] out_temperature_centi;
  logic [31:0] out_pressure_pa;
  logic        out_divide_fault;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  comp_scoreboard sb;
  bit  no_gaps;
  int  idle_cycles = 0;

  pressure_sensor_compensation DUT (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Random wait of a side, or none while gaps are switched off.
  function int draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 4);
  endfunction

  task automatic write_reg(psc_reg_t idx, logic [63:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    sb.note_config(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_calibration(logic [47:0] tc, logic [63:0] lo, logic [63:0] hi,
                                  logic [15:0] nine);
    write_reg(REG_TEMP_COEFFS, {16'd0, tc});
    write_reg(REG_PRESS_LOW, lo);
    write_reg(REG_PRESS_HIGH, hi);
    write_reg(REG_PRESS_NINE, {48'd0, nine});
  endtask

  // One input transfer; called and returning at a falling edge.
  task automatic push_sample(logic [19:0] raw_p, logic [19:0] raw_t);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push = 1'b1;
    in_raw_pressure = raw_p;
    in_raw_temperature = raw_t;
    forever begin
      @(posedge clk);
      if (!in_full) break;
    end
    sb.note_input(raw_p, raw_t);
    @(negedge clk);
  endtask

  // Let every expected result arrive, then let the pipeline settle.
  task automatic drain();
    in_push = 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  function logic [19:0] rand_raw();
    case ($urandom_range(0, 9))
      0: return 20'd0;
      1: return 20'hFFFFF;
      default: return 20'($urandom_range(0, 20'hFFFFF));
    endcase
  endfunction

  // Raw samples, mostly near a real part's operating range, otherwise random or at the ends.
  task automatic random_samples(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 64 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0)
        push_sample(20'($urandom_range(200000, 600000)),
                    20'($urandom_range(400000, 600000)));
      else
        push_sample(rand_raw(), rand_raw());
    end
    no_gaps = 1'b0;
  endtask

  // Result side: pop with random gaps and check each transfer.
  initial begin
    int gap;
    out_pop = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      gap = draw_gap();
      if (gap > 0) begin
        out_pop = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_pop = 1'b1;
      forever begin
        @(posedge clk);
        if (!out_empty) break;
      end
      sb.check_result(out_temperature_centi, out_pressure_pa, out_divide_fault);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Stimulus by calibration phase.
  initial begin
    sb = new();
    no_gaps = 1'b0;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_raw_pressure = '0;
    in_raw_temperature = '0;
    cfg_we = 1'b0;
    cfg_index = REG_TEMP_COEFFS;
    cfg_data = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Reset calibration: the divisor is zero, so every item faults.
    push_sample(20'd0, 20'd0);
    push_sample(20'hFFFFF, 20'hFFFFF);
    push_sample(20'd415148, 20'd519888);
    drain();

    // Typical factory calibration with directed samples.
    load_calibration({16'hFC18, 16'd26435, 16'd27504},
                     {16'd2855, 16'd3024, 16'hD643, 16'd36477},
                     {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000);
    push_sample(20'd415148, 20'd519888);
    push_sample(20'd0, 20'd0);
    push_sample(20'hFFFFF, 20'hFFFFF);
    push_sample(20'd0, 20'hFFFFF);
    push_sample(20'hFFFFF, 20'd0);
    push_sample(20'h55555, 20'hAAAAA);
    push_sample(20'hAAAAA, 20'h55555);
    random_samples(300);
    drain();

    // All coefficient bits set.
    load_calibration('1, '1, '1, '1);
    push_sample(20'd0, 20'd0);
    push_sample(20'hFFFFF, 20'hFFFFF);
    random_samples(150);
    drain();

    // Largest positive signed coefficients and largest unsigned ones.
    load_calibration({16'h7FFF, 16'h7FFF, 16'hFFFF},
                     {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF},
                     {4{16'h7FFF}}, 16'h7FFF);
    random_samples(150);
    drain();

    // Most negative signed coefficients.
    load_calibration({16'h8000, 16'h8000, 16'h0001},
                     {16'h8000, 16'h8000, 16'h8000, 16'h0001},
                     {4{16'h8000}}, 16'h8000);
    random_samples(150);
    drain();

    // Fully random calibrations, one of them with P1 zero for the fault path.
    for (int k = 0; k < 7; k++) begin
      load_calibration(48'({$urandom, $urandom}),
                       {$urandom, 16'($urandom), 16'(k == 2 ? 0 : $urandom)},
                       {$urandom, $urandom}, 16'($urandom));
      random_samples(150);
      drain();
    end

    if (sb.errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
